@@ hdl/rtc_pkg.sv @@
// Shared types, constants and the month-length lookup for the RTC calendar.
// Used by rtc_cell and rtc_calendar_with_alarm; depends on nothing else.
package rtc_pkg;

  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int TENTH_OUT_W = 4;
  localparam int CFG_DATA_W  = 6;

  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;
  localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;
  localparam int YEAR_RST = 2000;
  localparam int DAY_FIRST = 1;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SET_TIME = 2'd1,
    MODE_SET_DATE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_ALARM_EN   = 2'd0,
    REG_ALARM_HOUR = 2'd1,
    REG_ALARM_MIN  = 2'd2,
    REG_ALARM_SEC  = 2'd3
  } cfg_reg_t;

  // Per-cell control: step on carry-in, or load a new value.
  typedef struct packed {
    logic step;
    logic load;
  } cell_ctl_t;

  // Month lengths; column 0 is a leap year, column 1 is not.
  localparam logic [DAY_W-1:0] MONTH_LEN_TAB [12][2] = '{
    '{5'd31, 5'd31}, '{5'd29, 5'd28}, '{5'd31, 5'd31}, '{5'd30, 5'd30},
    '{5'd31, 5'd31}, '{5'd30, 5'd30}, '{5'd31, 5'd31}, '{5'd31, 5'd31},
    '{5'd30, 5'd30}, '{5'd31, 5'd31}, '{5'd30, 5'd30}, '{5'd31, 5'd31}
  };

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic [YEAR_W-1:0] year);
    logic col;
    col = (year[1:0] != 2'b00);
    if (month > MONTH_LAST) begin
      return 5'd31;
    end
    return MONTH_LEN_TAB[month][col];
  endfunction

endpackage

@@ hdl/rtc_cell.sv @@
// One counter cell of the calendar chain: counts on carry-in, wraps past
// its last value and hands the carry to the next cell. Depends on rtc_pkg.
module rtc_cell #(
  parameter int W        = 6,
  parameter int RST_VAL  = 0,
  parameter int WRAP_VAL = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rtc_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      last_val,
  input  logic [W-1:0]      load_val,
  output logic [W-1:0]      value,
  output logic              carry_out
);
  import rtc_pkg::*;

  logic [W-1:0] value_r;
  logic [W-1:0] value_nxt;
  logic         wrap;

  // Wrap on reaching or passing the last value.
  assign wrap      = (value_r >= last_val);
  assign carry_out = ctl.step & wrap;
  assign value     = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.load) begin
      value_nxt = load_val;
    end else if (ctl.step) begin
      value_nxt = wrap ? W'(WRAP_VAL) : value_r + W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= W'(RST_VAL);
    end else begin
      value_r <= value_nxt;
    end
  end

endmodule

@@ hdl/rtc_calendar_with_alarm.sv @@
// Top level of the real-time clock calendar with alarm.
// Depends on rtc_pkg and rtc_cell.
//
// Use:
//   Input stream: in_tuser carries the mode (tick, set time, set date),
//   in_tdata the set fields. Each accepted transaction gives exactly one
//   result transaction with the full time and date after that step, plus
//   alarm_hit and set_error in out_tuser.
//   The counters form a chain of seven cells (tenths to year); a tick
//   ripples its carry through the chain within the accepting cycle.
//   Latency: the result is valid in the cycle after acceptance.
//   Throughput: one transaction per cycle; the output register is reloaded
//   in the same cycle it is taken, so in_tready stays high while the
//   receiver keeps out_tready high.
//   Stall: while a result waits with out_tready low, in_tready is low and
//   the counters hold.
//   Alarm registers are written over the cfg channel (always ready).
//   Reset: synchronous, active low; time 00:00:00.0, 1 January 2000,
//   alarm disarmed, no result pending.
module rtc_calendar_with_alarm #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: set_hour[4:0], set_minute[10:5], set_second[16:11],
  //           set_day[21:17], set_month[25:22], set_year[39:26]
  input  logic [39:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: tenth_now[3:0], second_now[9:4], minute_now[15:10],
  //            hour_now[20:16], day_now[25:21], month_now[29:26],
  //            year_now[43:30], zero pad [47:44]
  output logic [47:0] out_tdata,
  // out_tuser: alarm_hit[0], set_error[1]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import rtc_pkg::*;

  localparam int TW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [TW-1:0] TENTH_LAST = TW'(TICKS_PER_SECOND - 1);

  // input fields
  logic [HOUR_W-1:0]  set_hour;
  logic [MIN_W-1:0]   set_minute;
  logic [SEC_W-1:0]   set_second;
  logic [DAY_W-1:0]   set_day;
  logic [MONTH_W-1:0] set_month;
  logic [YEAR_W-1:0]  set_year;

  assign set_hour   = in_tdata[4:0];
  assign set_minute = in_tdata[10:5];
  assign set_second = in_tdata[16:11];
  assign set_day    = in_tdata[21:17];
  assign set_month  = in_tdata[25:22];
  assign set_year   = in_tdata[39:26];

  // alarm registers
  logic               alarm_en_r;
  logic [HOUR_W-1:0]  alarm_hour_r;
  logic [MIN_W-1:0]   alarm_min_r;
  logic [SEC_W-1:0]   alarm_sec_r;

  // output stage
  logic out_valid_r;
  logic alarm_hit_r;
  logic set_error_r;
  logic alarm_hit_nxt;
  logic set_error_nxt;

  logic in_accept;
  logic is_tick;
  logic is_set_time;
  logic is_set_date;
  logic time_ok;
  logic date_ok;

  // chain values and carries
  logic [TW-1:0]      tenth_val;
  logic [SEC_W-1:0]   sec_val;
  logic [MIN_W-1:0]   min_val;
  logic [HOUR_W-1:0]  hour_val;
  logic [DAY_W-1:0]   day_val;
  logic [MONTH_W-1:0] month_val;
  logic [YEAR_W-1:0]  year_val;
  logic c_tenth, c_sec, c_min, c_hour, c_day, c_month, c_year;
  logic [DAY_W-1:0]   day_last;
  logic [TW+TENTH_OUT_W-1:0] tenth_ext;

  cell_ctl_t ctl_tenth, ctl_sec, ctl_min, ctl_hour, ctl_day, ctl_month, ctl_year;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign is_tick     = in_accept && (in_tuser == MODE_TICK);
  assign is_set_time = in_accept && (in_tuser == MODE_SET_TIME);
  assign is_set_date = in_accept && (in_tuser == MODE_SET_DATE);

  assign time_ok = (set_hour <= HOUR_LAST) && (set_minute <= MIN_LAST) &&
                   (set_second <= SEC_LAST);
  assign date_ok = (set_month <= MONTH_LAST) && (set_year <= YEAR_LAST) &&
                   (set_day != '0) && (set_day <= month_len(set_month, set_year));

  // Day rolls over after the last day of the current month.
  assign day_last = month_len(month_val, year_val);

  assign ctl_tenth = '{step: is_tick, load: 1'b0};
  assign ctl_sec   = '{step: c_tenth, load: is_set_time && time_ok};
  assign ctl_min   = '{step: c_sec,   load: is_set_time && time_ok};
  assign ctl_hour  = '{step: c_min,   load: is_set_time && time_ok};
  assign ctl_day   = '{step: c_hour,  load: is_set_date && date_ok};
  assign ctl_month = '{step: c_day,   load: is_set_date && date_ok};
  assign ctl_year  = '{step: c_month, load: is_set_date && date_ok};

  rtc_cell #(.W(TW), .RST_VAL(0), .WRAP_VAL(0)) u_tenth (
    .clk, .rst_n, .ctl(ctl_tenth), .last_val(TENTH_LAST), .load_val('0),
    .value(tenth_val), .carry_out(c_tenth)
  );
  rtc_cell #(.W(SEC_W), .RST_VAL(0), .WRAP_VAL(0)) u_sec (
    .clk, .rst_n, .ctl(ctl_sec), .last_val(SEC_LAST), .load_val(set_second),
    .value(sec_val), .carry_out(c_sec)
  );
  rtc_cell #(.W(MIN_W), .RST_VAL(0), .WRAP_VAL(0)) u_min (
    .clk, .rst_n, .ctl(ctl_min), .last_val(MIN_LAST), .load_val(set_minute),
    .value(min_val), .carry_out(c_min)
  );
  rtc_cell #(.W(HOUR_W), .RST_VAL(0), .WRAP_VAL(0)) u_hour (
    .clk, .rst_n, .ctl(ctl_hour), .last_val(HOUR_LAST), .load_val(set_hour),
    .value(hour_val), .carry_out(c_hour)
  );
  rtc_cell #(.W(DAY_W), .RST_VAL(DAY_FIRST), .WRAP_VAL(DAY_FIRST)) u_day (
    .clk, .rst_n, .ctl(ctl_day), .last_val(day_last), .load_val(set_day),
    .value(day_val), .carry_out(c_day)
  );
  rtc_cell #(.W(MONTH_W), .RST_VAL(0), .WRAP_VAL(0)) u_month (
    .clk, .rst_n, .ctl(ctl_month), .last_val(MONTH_LAST), .load_val(set_month),
    .value(month_val), .carry_out(c_month)
  );
  rtc_cell #(.W(YEAR_W), .RST_VAL(YEAR_RST), .WRAP_VAL(0)) u_year (
    .clk, .rst_n, .ctl(ctl_year), .last_val(YEAR_LAST), .load_val(set_year),
    .value(year_val), .carry_out(c_year)
  );

  // Compare the alarm against the time before this tick's increment.
  assign alarm_hit_nxt = c_tenth && alarm_en_r && (sec_val == alarm_sec_r) &&
                         (min_val == alarm_min_r) && (hour_val == alarm_hour_r);
  assign set_error_nxt = (is_set_time && !time_ok) || (is_set_date && !date_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      alarm_hit_r <= 1'b0;
      set_error_r <= 1'b0;
    end else begin
      if (in_accept) begin
        out_valid_r <= 1'b1;
        alarm_hit_r <= alarm_hit_nxt;
        set_error_r <= set_error_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_en_r   <= 1'b0;
      alarm_hour_r <= '0;
      alarm_min_r  <= '0;
      alarm_sec_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALARM_EN:   alarm_en_r   <= cfg_data[0];
        REG_ALARM_HOUR: alarm_hour_r <= cfg_data[HOUR_W-1:0];
        REG_ALARM_MIN:  alarm_min_r  <= cfg_data[MIN_W-1:0];
        REG_ALARM_SEC:  alarm_sec_r  <= cfg_data[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Counters only move on acceptance, so they hold the pending result.
  assign tenth_ext  = {{TENTH_OUT_W{1'b0}}, tenth_val};
  assign out_tdata  = {4'b0000, year_val, month_val, day_val, hour_val,
                       min_val, sec_val, tenth_ext[TENTH_OUT_W-1:0]};
  assign out_tuser  = {set_error_r, alarm_hit_r};
  assign out_tvalid = out_valid_r;

  // A result never reports both an alarm and a rejected set.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(alarm_hit_r && set_error_r))
    else $error("alarm_hit and set_error raised together");

  // The calendar date (day, month, year) stays within its legal range.
  a_calendar_range: assert property (@(posedge clk) disable iff (!rst_n)
    (day_val != '0) && (day_val <= day_last) && (month_val <= MONTH_LAST) &&
    (year_val <= YEAR_LAST))
    else $error("calendar counters out of range");

  // A rejected set leaves every time and date counter untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    set_error_nxt |=> ($stable(sec_val) && $stable(min_val) && $stable(hour_val) &&
                       $stable(day_val) && $stable(month_val) && $stable(year_val) &&
                       $stable(tenth_val)))
    else $error("rejected set changed the counters");

endmodule
